// ===== hdl/socks5_udp_header_deframer_macros.svh =====
// Assertion macros used by the deframer checker.
// No dependencies; included by name where assertions are written.
`ifndef SOCKS5_UDP_HEADER_DEFRAMER_MACROS_SVH
`define SOCKS5_UDP_HEADER_DEFRAMER_MACROS_SVH

// same-cycle implication
`define S5U_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define S5U_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/s5u_pkg.sv =====
// Shared constants and types of the SOCKS5 UDP header deframer.
// No dependencies; imported by every module of the block except s5u_ram.
package s5u_pkg;

    localparam int NAME_DEPTH = 256;
    localparam int NAME_AW    = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;

    localparam int          POS_W   = 9;
    localparam logic [8:0]  POS_MAX = 9'd511;

    localparam logic [8:0] RSV_BYTES     = 9'd3;
    localparam logic [8:0] TYPE_POS      = 9'd3;
    localparam logic [8:0] ADDR_POS      = 9'd4;
    localparam logic [8:0] NAME_POS      = 9'd5;
    localparam logic [8:0] HDR_LEN_IPV4  = 9'd10;
    localparam logic [8:0] HDR_LEN_IPV6  = 9'd22;
    localparam logic [8:0] NAME_HDR_BASE = 9'd7;

    localparam logic [7:0] ATYP_IPV4 = 8'd1;
    localparam logic [7:0] ATYP_NAME = 8'd3;
    localparam logic [7:0] ATYP_IPV6 = 8'd4;

    localparam logic ACTION_DATA = 1'b0;
    localparam logic ACTION_LOAD = 1'b1;

    localparam int CFG_AW = 6;
    localparam logic [2:0] REG_DEST_TYPE      = 3'd0;
    localparam logic [2:0] REG_DEST_PORT      = 3'd1;
    localparam logic [2:0] REG_DEST_ADDR_HIGH = 3'd2;
    localparam logic [2:0] REG_DEST_ADDR_LOW  = 3'd3;
    localparam logic [2:0] REG_DEST_NAME_LEN  = 3'd4;
    localparam logic [2:0] REG_MAX_PAYLOAD    = 3'd5;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd2048;
    localparam logic [15:0] COUNT_MAX         = 16'hffff;

    // power of two, pointers wrap at the depth
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_MALFORMED  = 2'd1,
        STATUS_UNEXPECTED = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  dest_type;
        logic [15:0] dest_port;
        logic [63:0] dest_addr_high;
        logic [63:0] dest_addr_low;
        logic [7:0]  dest_name_length;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             end_of_packet;
        logic             truncated;
        logic [POS_W-1:0] pos;
        logic             name_ok;
        logic [7:0]       name_byte;
    } q_entry_t;

endpackage

// ===== hdl/s5u_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module s5u_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/s5u_front.sv =====
// Front stage: accepts items, tracks byte position, owns the name store.
// Depends on s5u_pkg and s5u_ram; feeds s5u_queue.
module s5u_front import s5u_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_data_byte,
    input  logic [7:0] s_name_index,
    input  logic       s_end_of_packet,
    input  logic       s_truncated,
    output logic       q_push,
    output q_entry_t   q_entry,
    input  logic       q_full
);

    logic             fv_reg, fv_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       data_reg;
    logic             eop_reg, trunc_reg, name_ok_reg;
    logic [POS_W-1:0] ipos_reg;

    logic             accept, is_data, is_load;
    logic [POS_W-1:0] name_off;
    logic             name_ok;
    logic             load_ok;
    logic [7:0]       name_byte;

    assign s_ready = !fv_reg || !q_full;
    assign accept  = s_valid && s_ready;
    assign is_data = accept && (s_action == ACTION_DATA);
    assign is_load = accept && (s_action == ACTION_LOAD);
    assign q_push  = fv_reg && !q_full;

    assign name_off = pos_reg - NAME_POS;
    assign name_ok  = (pos_reg >= NAME_POS) &&
                      ({1'b0, name_off} < (POS_W + 1)'(NAME_DEPTH));
    assign load_ok  = {1'b0, s_name_index} < 9'(NAME_DEPTH);

    s5u_ram #(.WIDTH(8), .DEPTH(NAME_DEPTH)) u_name_ram (
        .aclk  (aclk),
        .we    (is_load && load_ok),
        .waddr (s_name_index[NAME_AW-1:0]),
        .wdata (s_data_byte),
        .re    (is_data && name_ok),
        .raddr (name_off[NAME_AW-1:0]),
        .rdata (name_byte)
    );

    always_comb begin
        fv_next  = fv_reg;
        pos_next = pos_reg;
        if (is_data) begin
            fv_next = 1'b1;
            if (s_end_of_packet) begin
                pos_next = '0;
            end else if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + 1'b1;
            end
        end else if (q_push) begin
            fv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg  <= 1'b0;
            pos_reg <= '0;
        end else begin
            fv_reg  <= fv_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_data) begin
            data_reg    <= s_data_byte;
            eop_reg     <= s_end_of_packet;
            trunc_reg   <= s_truncated;
            ipos_reg    <= pos_reg;
            name_ok_reg <= name_ok;
        end
    end

    always_comb begin
        q_entry.data_byte     = data_reg;
        q_entry.end_of_packet = eop_reg;
        q_entry.truncated     = trunc_reg;
        q_entry.pos           = ipos_reg;
        q_entry.name_ok       = name_ok_reg;
        q_entry.name_byte     = name_byte;
    end

endmodule

// ===== hdl/s5u_queue.sv =====
// Short FIFO between the front and back stages.
// Depends on s5u_pkg.
module s5u_queue import s5u_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output q_entry_t head
);

    q_entry_t         entries_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]    count_reg, count_next;

    assign full       = (count_reg == (Q_AW + 1)'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/s5u_back.sv =====
// Back stage: header checks, source compare, payload count and result register.
// Depends on s5u_pkg; fed by s5u_queue.
module s5u_back import s5u_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  q_entry_t   q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic       m_payload_valid,
    output logic       m_packet_done,
    output logic [1:0] m_status
);

    logic [2:0]       src_type_reg, src_type_next;
    logic [POS_W-1:0] hdr_len_reg, hdr_len_next;
    logic             addr_match_reg, addr_match_next;
    logic [15:0]      src_port_reg, src_port_next;
    logic             malformed_reg, malformed_next;
    logic [15:0]      pay_cnt_reg, pay_cnt_next;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       pbyte_reg;
    logic             pvalid_reg, done_reg;
    status_t          status_reg, status_next;

    logic             take, emit, pay_valid, mal_final;
    logic [7:0]       b;
    logic [POS_W-1:0] p, k;
    logic [127:0]     addr128;
    logic [7:0]       exp_v4, exp_v6;
    logic             addr_eq;

    assign take    = q_valid && (!m_valid_reg || m_ready);
    assign q_pop   = take;
    assign b       = q_head.data_byte;
    assign p       = q_head.pos;
    assign k       = p - ADDR_POS;
    assign addr128 = {cfg.dest_addr_high, cfg.dest_addr_low};
    assign exp_v4  = cfg.dest_addr_low[{~k[1:0], 3'b000} +: 8];
    assign exp_v6  = addr128[{~k[3:0], 3'b000} +: 8];

    always_comb begin
        if (src_type_reg == ATYP_IPV4[2:0]) begin
            addr_eq = (exp_v4 == b);
        end else if (src_type_reg == ATYP_IPV6[2:0]) begin
            addr_eq = (exp_v6 == b);
        end else begin
            addr_eq = q_head.name_ok && (q_head.name_byte == b);
        end
    end

    always_comb begin
        src_type_next   = src_type_reg;
        hdr_len_next    = hdr_len_reg;
        addr_match_next = addr_match_reg;
        src_port_next   = src_port_reg;
        malformed_next  = malformed_reg;
        pay_cnt_next    = pay_cnt_reg;
        pay_valid       = 1'b0;
        mal_final       = 1'b0;
        status_next     = STATUS_OK;

        if (take && !malformed_reg) begin
            if (p < RSV_BYTES) begin
                if (b != 8'd0) begin
                    malformed_next = 1'b1;
                end
            end else if (p == TYPE_POS) begin
                if (b != {5'd0, cfg.dest_type}) begin
                    addr_match_next = 1'b0;
                end
                case (b)
                    ATYP_IPV4: begin
                        src_type_next = b[2:0];
                        hdr_len_next  = HDR_LEN_IPV4;
                    end
                    ATYP_IPV6: begin
                        src_type_next = b[2:0];
                        hdr_len_next  = HDR_LEN_IPV6;
                    end
                    ATYP_NAME: begin
                        src_type_next = b[2:0];
                        hdr_len_next  = '0;
                    end
                    default: malformed_next = 1'b1;
                endcase
            end else if (p == ADDR_POS && src_type_reg == ATYP_NAME[2:0]) begin
                if (b == 8'd0) begin
                    malformed_next = 1'b1;
                end else begin
                    hdr_len_next = NAME_HDR_BASE + {1'b0, b};
                    if (b != cfg.dest_name_length) begin
                        addr_match_next = 1'b0;
                    end
                end
            end else if (hdr_len_reg != '0 && p < hdr_len_reg) begin
                if (({1'b0, p} + 10'd2) >= {1'b0, hdr_len_reg}) begin
                    src_port_next = {src_port_reg[7:0], b};
                end else if (!addr_eq) begin
                    addr_match_next = 1'b0;
                end
            end else if (hdr_len_reg != '0) begin
                if (pay_cnt_reg >= cfg.max_payload) begin
                    malformed_next = 1'b1;
                end else begin
                    pay_valid = 1'b1;
                end
                if (pay_cnt_reg != COUNT_MAX) begin
                    pay_cnt_next = pay_cnt_reg + 1'b1;
                end
            end
        end

        if (take && q_head.end_of_packet) begin
            mal_final = malformed_next || q_head.truncated || (hdr_len_next == '0) ||
                        (({1'b0, p} + 10'd1) < {1'b0, hdr_len_next});
            if (mal_final) begin
                status_next = STATUS_MALFORMED;
            end else if ((src_port_next != cfg.dest_port) ||
                         (cfg.dest_type != ATYP_NAME[2:0] && !addr_match_next) ||
                         (src_type_next == ATYP_NAME[2:0] && !addr_match_next)) begin
                status_next = STATUS_UNEXPECTED;
            end
            src_type_next   = '0;
            hdr_len_next    = '0;
            addr_match_next = 1'b1;
            src_port_next   = '0;
            malformed_next  = 1'b0;
            pay_cnt_next    = '0;
        end
    end

    assign emit = take && (pay_valid || q_head.end_of_packet);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_type_reg   <= '0;
            hdr_len_reg    <= '0;
            addr_match_reg <= 1'b1;
            src_port_reg   <= '0;
            malformed_reg  <= 1'b0;
            pay_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            src_type_reg   <= src_type_next;
            hdr_len_reg    <= hdr_len_next;
            addr_match_reg <= addr_match_next;
            src_port_reg   <= src_port_next;
            malformed_reg  <= malformed_next;
            pay_cnt_reg    <= pay_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            pbyte_reg  <= pay_valid ? b : 8'd0;
            pvalid_reg <= pay_valid;
            done_reg   <= q_head.end_of_packet;
            status_reg <= status_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_payload_byte  = pbyte_reg;
    assign m_payload_valid = pvalid_reg;
    assign m_packet_done   = done_reg;
    assign m_status        = status_reg;

endmodule

// ===== hdl/socks5_udp_header_deframer.sv =====
// SOCKS5 UDP relay header deframer: top level with the register port.
// Depends on s5u_pkg, s5u_front, s5u_queue and s5u_back.
//
// s_* carries one item per handshake: a datagram byte (action 0) or a
// destination name byte to store (action 1, at name_index). Datagram bytes
// give a result on m_* when they are payload or the final byte of the
// datagram; the final byte's result carries packet_done and the status.
// Name loads and header bytes give no result.
// Registers sit on the APB port at byte address 8*index, 64-bit data:
// dest_type, dest_port, dest_addr_high, dest_addr_low, dest_name_length,
// max_payload. Write them only while no datagram is in flight.
// Throughput is one item per cycle while m_ready keeps up; a result passes the
// front register, the queue and the result register before it shows on m_valid.
// The front stage reads the name store as it accepts a byte; the queue carries it to the compare.
// Reset clears the packet state and queue and loads the register defaults;
// the name store is not cleared and must be loaded before use.
// When m_ready is low the result register holds, the two-entry queue and
// the front register fill, and s_ready drops after three more items.
module socks5_udp_header_deframer import s5u_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic [7:0]        s_data_byte,
    input  logic [7:0]        s_name_index,
    input  logic              s_end_of_packet,
    input  logic              s_truncated,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_payload_byte,
    output logic              m_payload_valid,
    output logic              m_packet_done,
    output logic [1:0]        m_status,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       cfg_we;
    logic       q_push, q_full, q_pop, q_valid;
    q_entry_t   q_in, q_head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_type        <= ATYP_IPV4[2:0];
            cfg_reg.dest_port        <= '0;
            cfg_reg.dest_addr_high   <= '0;
            cfg_reg.dest_addr_low    <= '0;
            cfg_reg.dest_name_length <= '0;
            cfg_reg.max_payload      <= MAX_PAYLOAD_RESET;
        end else if (cfg_we) begin
            case (reg_idx)
                REG_DEST_TYPE:      cfg_reg.dest_type        <= pwdata[2:0];
                REG_DEST_PORT:      cfg_reg.dest_port        <= pwdata[15:0];
                REG_DEST_ADDR_HIGH: cfg_reg.dest_addr_high   <= pwdata;
                REG_DEST_ADDR_LOW:  cfg_reg.dest_addr_low    <= pwdata;
                REG_DEST_NAME_LEN:  cfg_reg.dest_name_length <= pwdata[7:0];
                REG_MAX_PAYLOAD:    cfg_reg.max_payload      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEST_TYPE:      prdata = {61'd0, cfg_reg.dest_type};
            REG_DEST_PORT:      prdata = {48'd0, cfg_reg.dest_port};
            REG_DEST_ADDR_HIGH: prdata = cfg_reg.dest_addr_high;
            REG_DEST_ADDR_LOW:  prdata = cfg_reg.dest_addr_low;
            REG_DEST_NAME_LEN:  prdata = {56'd0, cfg_reg.dest_name_length};
            REG_MAX_PAYLOAD:    prdata = {48'd0, cfg_reg.max_payload};
            default:            prdata = '0;
        endcase
    end

    s5u_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_data_byte     (s_data_byte),
        .s_name_index    (s_name_index),
        .s_end_of_packet (s_end_of_packet),
        .s_truncated     (s_truncated),
        .q_push          (q_push),
        .q_entry         (q_in),
        .q_full          (q_full)
    );

    s5u_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    s5u_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_valid         (q_valid),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_payload_valid (m_payload_valid),
        .m_packet_done   (m_packet_done),
        .m_status        (m_status)
    );

endmodule

// ===== hdl/s5u_checker.sv =====
// Port-level checks on the deframer result channel, bound to the top level.
// Depends on s5u_pkg and socks5_udp_header_deframer_macros.svh.
`include "socks5_udp_header_deframer_macros.svh"

module s5u_checker import s5u_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_payload_byte,
    input logic       m_payload_valid,
    input logic       m_packet_done,
    input logic [1:0] m_status
);

    `S5U_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_payload_byte) && $stable(m_status) &&
        $stable(m_packet_done) && $stable(m_payload_valid),
        "stalled result item changed")
    `S5U_ASSERT_IMPLIES(a_nonempty, aclk, aresetn, m_valid,
        m_payload_valid || m_packet_done, "result item carries neither payload nor end")
    `S5U_ASSERT_IMPLIES(a_status_mid, aclk, aresetn, m_valid && !m_packet_done,
        m_status == STATUS_OK, "status set before end of datagram")
    `S5U_ASSERT_IMPLIES(a_byte_zero, aclk, aresetn, m_valid && !m_payload_valid,
        m_payload_byte == 8'd0 && m_status != 2'd3, "non-payload item has data or bad status")

endmodule

bind socks5_udp_header_deframer s5u_checker u_s5u_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking regression for socks5_udp_header_deframer: random relay datagrams,
// name loads and register settings, checked item by item against a header tracker.
// Depends on s5u_pkg and the RTL of the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import s5u_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 8;
    localparam int PHASE_BYTES = 55;
    localparam int NAME_LOADS  = 64;
    localparam logic [2:0] TYPE_UNASSIGNED = 3'd2;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic [7:0] name_index;
        logic       end_of_packet;
        logic       truncated;
    } item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       packet_done;
        status_t    status;
    } result_t;

    typedef enum {
        FRAME_GOOD, FRAME_OTHER_TYPE, FRAME_BAD_PORT, FRAME_BAD_ADDR, FRAME_RESERVED,
        FRAME_UNKNOWN_TYPE, FRAME_EMPTY_NAME, FRAME_SHORT, FRAME_TRUNCATED,
        FRAME_OVERSIZE, FRAME_NOISE
    } frame_kind_e;

    class header_tracker;
        logic [2:0]  dest_type;
        logic [15:0] dest_port;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  name_len;
        logic [15:0] max_payload;
        logic [7:0]  name_store [NAME_DEPTH];

        logic [8:0]  pos;
        logic [7:0]  src_type;
        logic [8:0]  hdr_len;
        bit          addr_ok;
        logic [15:0] src_port;
        bit          bad;
        logic [15:0] pay_cnt;

        result_t due_results [$];
        int errors, results_seen, n_ok, n_malformed, n_unexpected;

        function new();
            dest_type   = ATYP_IPV4[2:0];
            dest_port   = '0;
            addr_hi     = '0;
            addr_lo     = '0;
            name_len    = '0;
            max_payload = MAX_PAYLOAD_RESET;
            foreach (name_store[i]) name_store[i] = '0;
            clear_packet();
        endfunction

        function void clear_packet();
            pos      = '0;
            src_type = '0;
            hdr_len  = '0;
            addr_ok  = 1'b1;
            src_port = '0;
            bad      = 1'b0;
            pay_cnt  = '0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                REG_DEST_TYPE:      dest_type   = v[2:0];
                REG_DEST_PORT:      dest_port   = v[15:0];
                REG_DEST_ADDR_HIGH: addr_hi     = v;
                REG_DEST_ADDR_LOW:  addr_lo     = v;
                REG_DEST_NAME_LEN:  name_len    = v[7:0];
                REG_MAX_PAYLOAD:    max_payload = v[15:0];
                default: ;
            endcase
        endfunction

        // 256 means no byte can match
        function int addr_byte(int p);
            int k;
            k = p - 4;
            if (src_type == ATYP_IPV4) begin
                if (k > 3) return 256;
                return addr_lo[8*(3-k) +: 8];
            end
            if (src_type == ATYP_IPV6) begin
                if (k > 15) return 256;
                if (k < 8) return addr_hi[8*(7-k) +: 8];
                return addr_lo[8*(15-k) +: 8];
            end
            if (p < NAME_POS || p - 5 >= NAME_DEPTH) return 256;
            return name_store[p-5];
        endfunction

        function void take_item(item_t it);
            int p;
            bit valid;
            logic [7:0] b;
            result_t r;
            p = pos;
            b = it.data_byte;
            valid = 1'b0;
            if (it.action == ACTION_LOAD) begin
                name_store[it.name_index] = b;
                return;
            end
            if (!bad) begin
                if (p < RSV_BYTES) begin
                    if (b != 0) bad = 1'b1;
                end else if (p == TYPE_POS) begin
                    if (b != dest_type) addr_ok = 1'b0;
                    if (b == ATYP_IPV4) begin
                        src_type = b;
                        hdr_len  = HDR_LEN_IPV4;
                    end else if (b == ATYP_IPV6) begin
                        src_type = b;
                        hdr_len  = HDR_LEN_IPV6;
                    end else if (b == ATYP_NAME) begin
                        src_type = b;
                        hdr_len  = '0;
                    end else begin
                        bad = 1'b1;
                    end
                end else if (p == ADDR_POS && src_type == ATYP_NAME) begin
                    if (b == 0) begin
                        bad = 1'b1;
                    end else begin
                        hdr_len = NAME_HDR_BASE + b;
                        if (b != name_len) addr_ok = 1'b0;
                    end
                end else if (hdr_len != 0 && p < hdr_len) begin
                    if (p + 2 >= hdr_len) src_port = {src_port[7:0], b};
                    else if (addr_byte(p) != b) addr_ok = 1'b0;
                end else if (hdr_len != 0) begin
                    if (pay_cnt >= max_payload) bad = 1'b1;
                    else valid = 1'b1;
                    if (pay_cnt != COUNT_MAX) pay_cnt++;
                end
            end
            if (pos != POS_MAX) pos++;
            if (!valid && !it.end_of_packet) return;

            r.payload_byte  = valid ? b : 8'h00;
            r.payload_valid = valid;
            r.packet_done   = it.end_of_packet;
            r.status        = STATUS_OK;
            if (it.end_of_packet) begin
                if (!bad && (it.truncated || hdr_len == 0 || p + 1 < hdr_len)) bad = 1'b1;
                if (bad) begin
                    r.status = STATUS_MALFORMED;
                    n_malformed++;
                end else if (src_port != dest_port
                             || (dest_type != ATYP_NAME && !addr_ok)
                             || (src_type == ATYP_NAME && !addr_ok)) begin
                    r.status = STATUS_UNEXPECTED;
                    n_unexpected++;
                end else begin
                    n_ok++;
                end
                clear_packet();
            end
            due_results.insert(due_results.size(), r);
        endfunction

        function void field_check(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $error("%s: expected %0h, got %0h", field, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0) begin
                errors++;
                $error("result with none pending: payload_byte %0h packet_done %0b",
                       got.payload_byte, got.packet_done);
                return;
            end
            want = due_results.pop_front();
            results_seen++;
            field_check("payload_byte", want.payload_byte, got.payload_byte);
            field_check("payload_valid", want.payload_valid, got.payload_valid);
            field_check("packet_done", want.packet_done, got.packet_done);
            field_check("status", want.status, got.status);
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_action = 1'b0;
    logic [7:0]        s_data_byte = '0;
    logic [7:0]        s_name_index = '0;
    logic              s_end_of_packet = 1'b0;
    logic              s_truncated = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [7:0]        m_payload_byte;
    logic              m_payload_valid;
    logic              m_packet_done;
    logic [1:0]        m_status;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [63:0]       pwdata = '0;
    logic [63:0]       prdata;
    logic              pready;

    socks5_udp_header_deframer i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_data_byte     (s_data_byte),
        .s_name_index    (s_name_index),
        .s_end_of_packet (s_end_of_packet),
        .s_truncated     (s_truncated),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_payload_valid (m_payload_valid),
        .m_packet_done   (m_packet_done),
        .m_status        (m_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    header_tracker tracker;
    logic [7:0] frame [$];
    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_request = 1'b0;
    int  hold_left = 0;
    int  idle_cycles = 0;
    int  data_items = 0;
    int  load_items = 0;
    int  reg_writes = 0;

    function automatic void frame_add(logic [7:0] v);
        frame.insert(frame.size(), v);
    endfunction

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: check, then decide ready for the next cycle
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.payload_byte  = m_payload_byte;
            got.payload_valid = m_payload_valid;
            got.packet_done   = m_packet_done;
            got.status        = status_t'(m_status);
            tracker.check_result(got);
        end
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", idle_cycles);
            $display("socks5_udp_header_deframer regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(item_t it);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_action        <= it.action;
        s_data_byte     <= it.data_byte;
        s_name_index    <= it.name_index;
        s_end_of_packet <= it.end_of_packet;
        s_truncated     <= it.truncated;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_item(it);
        if (it.action == ACTION_LOAD) load_items++;
        else data_items++;
    endtask

    task automatic load_name(logic [7:0] idx, logic [7:0] val);
        item_t it;
        it.action        = ACTION_LOAD;
        it.data_byte     = val;
        it.name_index    = idx;
        it.end_of_packet = 1'($urandom_range(1));
        it.truncated     = 1'($urandom_range(1));
        send_item(it);
    endtask

    task automatic send_frame(bit trunc);
        item_t it;
        foreach (frame[i]) begin
            it.action        = ACTION_DATA;
            it.data_byte     = frame[i];
            it.name_index    = 8'($urandom_range(255));
            it.end_of_packet = (i == frame.size() - 1);
            it.truncated     = it.end_of_packet ? trunc : 1'($urandom_range(1));
            send_item(it);
        end
    endtask

    // pay_len < 0 picks a random length, at times from the current payload limit when it is at most 64
    task automatic build_frame(frame_kind_e kind, int pay_len);
        logic [7:0] st;
        logic [7:0] v;
        int nlen, hdr, k;
        bit numeric_dest;
        numeric_dest = (tracker.dest_type == ATYP_IPV4 || tracker.dest_type == ATYP_NAME
                        || tracker.dest_type == ATYP_IPV6);
        do begin
            case ($urandom_range(2))
                0:       st = ATYP_IPV4;
                1:       st = ATYP_NAME;
                default: st = ATYP_IPV6;
            endcase
        end while (kind == FRAME_OTHER_TYPE && st == tracker.dest_type);
        if (kind != FRAME_OTHER_TYPE && numeric_dest && $urandom_range(7) != 0)
            st = tracker.dest_type;

        frame = '{8'h00, 8'h00, 8'h00, st};
        if (st == ATYP_IPV4) begin
            for (k = 3; k >= 0; k--) frame_add(tracker.addr_lo[8*k +: 8]);
        end else if (st == ATYP_IPV6) begin
            for (k = 7; k >= 0; k--) frame_add(tracker.addr_hi[8*k +: 8]);
            for (k = 7; k >= 0; k--) frame_add(tracker.addr_lo[8*k +: 8]);
        end else begin
            nlen = tracker.name_len;
            if (nlen == 0 || tracker.dest_type != ATYP_NAME || $urandom_range(9) == 0)
                nlen = $urandom_range(1, 12);
            frame_add(8'(nlen));
            for (k = 0; k < nlen; k++) frame_add(tracker.name_store[k]);
        end
        frame_add(tracker.dest_port[15:8]);
        frame_add(tracker.dest_port[7:0]);
        hdr = frame.size();

        if (pay_len < 0) begin
            if (kind == FRAME_OVERSIZE && tracker.max_payload <= 64)
                pay_len = tracker.max_payload + $urandom_range(1, 3);
            else if (tracker.max_payload <= 64 && $urandom_range(3) == 0)
                pay_len = tracker.max_payload - $urandom_range(1);
            else
                pay_len = $urandom_range(0, 10);
        end
        for (k = 0; k < pay_len; k++) frame_add(8'($urandom_range(255)));

        case (kind)
            FRAME_BAD_PORT: frame[hdr - 1 - $urandom_range(1)] ^= 8'($urandom_range(1, 255));
            FRAME_BAD_ADDR: frame[$urandom_range(4, hdr - 3)] ^= 8'($urandom_range(1, 255));
            FRAME_RESERVED: frame[$urandom_range(2)] = 8'($urandom_range(1, 255));
            FRAME_UNKNOWN_TYPE: begin
                do v = 8'($urandom_range(255));
                while (v == ATYP_IPV4 || v == ATYP_NAME || v == ATYP_IPV6);
                frame[3] = v;
            end
            FRAME_EMPTY_NAME: begin
                frame = '{8'h00, 8'h00, 8'h00, ATYP_NAME, 8'h00};
                repeat ($urandom_range(0, 5)) frame_add(8'($urandom_range(255)));
            end
            FRAME_SHORT: begin
                k = $urandom_range(1, hdr - 1);
                while (frame.size() > k) void'(frame.pop_back());
            end
            FRAME_NOISE: begin
                frame.delete();
                repeat ($urandom_range(1, 10)) frame_add(8'($urandom_range(255)));
                if ($urandom_range(1)) frame[0] = 8'h00;
            end
            default: ;
        endcase
    endtask

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(idx, val);
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        logic [2:0]  ptype;
        logic [15:0] pmax;
        logic [7:0]  plen;
        int r;
        frame_kind_e kind;
        tracker = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // names never run past the loaded entries
        for (int i = 0; i < NAME_LOADS; i++) load_name(8'(i), 8'($urandom_range(255)));

        // directed: reset settings, one each of short, reserved, unknown type, empty name and truncated
        frame = '{8'h00};
        send_frame(1'b0);
        frame = '{8'h00, 8'h80, 8'h00, ATYP_IPV4};
        send_frame(1'b0);
        frame = '{8'h00, 8'h00, 8'h00, 8'hff};
        send_frame(1'b0);
        frame = '{8'h00, 8'h00, 8'h00, ATYP_NAME, 8'h00};
        send_frame(1'b0);
        frame = '{8'h00, 8'h00, 8'h00, ATYP_IPV4, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'hff, 8'h00};
        send_frame(1'b1);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            case (ph)
                1, 3, 5: ptype = ATYP_IPV6[2:0];
                2, 7:    ptype = ATYP_NAME[2:0];
                6:       ptype = TYPE_UNASSIGNED;
                default: ptype = ATYP_IPV4[2:0];
            endcase
            if (ph == 5) ptype = ATYP_NAME[2:0];
            case (ph)
                3:       pmax = 16'd1;
                4:       pmax = 16'hffff;
                7:       pmax = 16'($urandom_range(2, 8));
                default: pmax = MAX_PAYLOAD_RESET;
            endcase
            case (ph)
                2:       plen = 8'd1;
                5:       plen = 8'd48;
                6:       plen = 8'd0;
                default: plen = 8'($urandom_range(1, 24));
            endcase
            reg_write(REG_DEST_TYPE, 64'(ptype));
            reg_write(REG_DEST_PORT, (ph == 1) ? 64'hffff :
                                     (ph == 2) ? 64'h0 : 64'($urandom_range(65535)));
            reg_write(REG_DEST_ADDR_HIGH, (ph == 1) ? '1 : {$urandom, $urandom});
            reg_write(REG_DEST_ADDR_LOW, (ph == 1) ? '1 : (ph == 2) ? '0 : {$urandom, $urandom});
            reg_write(REG_DEST_NAME_LEN, 64'(plen));
            reg_write(REG_MAX_PAYLOAD, 64'(pmax));

            if (ph == 0) hold_request = 1'b1;
            r = data_items;
            while (data_items - r < PHASE_BYTES) begin
                if ($urandom_range(6) == 0)
                    repeat ($urandom_range(1, 3))
                        load_name(8'($urandom_range(255)), 8'($urandom_range(255)));
                case ($urandom_range(99)) inside
                    [0:39]:  kind = FRAME_GOOD;
                    [40:47]: kind = FRAME_OTHER_TYPE;
                    [48:55]: kind = FRAME_BAD_PORT;
                    [56:63]: kind = FRAME_BAD_ADDR;
                    [64:68]: kind = FRAME_RESERVED;
                    [69:73]: kind = FRAME_UNKNOWN_TYPE;
                    [74:77]: kind = FRAME_EMPTY_NAME;
                    [78:83]: kind = FRAME_SHORT;
                    [84:88]: kind = FRAME_TRUNCATED;
                    [89:93]: kind = FRAME_OVERSIZE;
                    default: kind = FRAME_NOISE;
                endcase
                build_frame(kind, -1);
                send_frame(kind == FRAME_TRUNCATED);
            end
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (tracker.due_results.size() != 0) begin
            tracker.errors++;
            $error("%0d results never arrived", tracker.due_results.size());
        end
        $display("covered %0d datagram bytes and %0d name loads under %0d register writes",
                 data_items, load_items, reg_writes);
        $display("checked %0d results; datagrams: %0d ok, %0d malformed, %0d unexpected source",
                 tracker.results_seen, tracker.n_ok, tracker.n_malformed, tracker.n_unexpected);
        if (tracker.errors == 0) begin
            $display("socks5_udp_header_deframer regression: pass");
        end else begin
            $display("socks5_udp_header_deframer regression: fail");
        end
        $finish;
    end
endmodule
